// ===== sv/vamr_pkg.sv =====
// Shared types, widths and status codes of the rotation matrix pipeline.
package vamr_pkg;

    localparam int RW   = 16;   // reduced vector component width
    localparam int QF   = 30;   // internal fraction bits
    localparam int PW   = 33;   // dot / cross product width, signed
    localparam int NW   = 32;   // squared norm width, unsigned
    localparam int OP_W = 64;   // square root operand width
    localparam int SQ_W = 32;   // square root result width
    localparam int TW   = 5;    // normalize count width (half shift)
    localparam int QB   = 32;   // quotient bits
    localparam int ST_W = 2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_PAR  = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic signed [PW-1:0]   d;
        logic [2:0][PW-1:0]     c;
        logic [TW-1:0]          tn;
        logic [TW-1:0]          tc;
        logic [ST_W-1:0]        status;
    } side_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            dpos;
    } tag_t;

    typedef struct packed {
        logic [SQ_W+1:0] rem;
        logic [SQ_W-1:0] root;
        logic [OP_W-1:0] op;
    } sq_t;

    typedef struct packed {
        logic [OP_W-1:0] rem;
        logic [SQ_W-1:0] den;
        logic [QB-1:0]   q;
        logic            neg;
    } dv_t;

endpackage

// ===== sv/vector_alignment_rotation_matrix.sv =====
// Top level: pipelined Rodrigues rotation matrix that turns vector u onto vector v.
// Throughput: one item per cycle; the whole pipe advances when the output register
// is empty or taken, so s_tready follows m_tready while a result is held.
// Cost is set by the 32-stage square root (two roots side by side) and the 32-stage
// restoring dividers (seven side by side). rst_n clears only the valid bits.
module vector_alignment_rotation_matrix #(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    // ux, uy, uz, vx, vy, vz (IN_WIDTH each, signed), zero pad to bytes
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((6*IN_WIDTH+7)/8)*8-1:0]             s_tdata,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (OUT_FRAC_BITS+2 each), zero pad
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]    m_tdata,
    // status
    output logic [vamr_pkg::ST_W-1:0]                   m_tuser
);
    import vamr_pkg::*;

    localparam int OUT_W  = OUT_FRAC_BITS + 2;
    localparam int XW     = (IN_WIDTH > RW) ? IN_WIDTH : RW;
    localparam int SW     = $clog2(XW + 1);
    localparam int NST    = 6 + SQ_W + 1 + QB + 6;
    localparam int RSH    = QF - OUT_FRAC_BITS;
    localparam int MW     = 72;     // wide product width
    localparam int EW     = 36;     // Q30 entry width
    localparam logic [EW-1:0]        HALF   = EW'((64'd1 << RSH) >> 1);
    localparam logic [EW-1:0]        ONE_O  = EW'(64'd1 << OUT_FRAC_BITS);
    localparam logic signed [EW-1:0] ONE_M  = EW'(64'd1 << QF);
    localparam logic signed [QB:0]   ONE_Q  = (QB+1)'(64'd1 << QF);

    // shift that brings all three components into 16 bits (floor shift)
    function automatic logic [SW-1:0] red_sh(input logic signed [XW-1:0] a0,
                                             input logic signed [XW-1:0] a1,
                                             input logic signed [XW-1:0] a2);
        logic [XW-1:0] z;
        logic [SW-1:0] s;
        z = (a0 ^ (a0 >>> 1)) | (a1 ^ (a1 >>> 1)) | (a2 ^ (a2 >>> 1));
        s = '0;
        for (int b = RW - 1; b < XW - 1; b++)
            if (z[b])
                s = SW'(b - (RW - 2));
        red_sh = s;
    endfunction

    // even left shift count / 2 that puts the msb in the top two bits
    function automatic logic [TW-1:0] lz_half(input logic [OP_W-1:0] p);
        logic [6:0] h;
        h = '0;
        for (int b = 0; b < OP_W; b++)
            if (p[b])
                h = 7'(b);
        lz_half = TW'((7'(OP_W - 1) - h) >> 1);
    endfunction

    // round half away from zero, drop QF fraction bits
    function automatic logic signed [EW-1:0] rnd_q(input logic signed [MW-1:0] v);
        logic [MW-1:0] mag;
        logic [MW-1:0] r;
        mag = v[MW-1] ? MW'(-v) : MW'(v);
        r   = (mag + (MW'(1) << (QF - 1))) >> QF;
        rnd_q = v[MW-1] ? -$signed(EW'(r)) : $signed(EW'(r));
    endfunction

    //------------------------------------------------------------------
    // Flow control: one valid bit per stage, global advance
    //------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic           en;

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    //------------------------------------------------------------------
    // S0: capture the item
    //------------------------------------------------------------------
    logic signed [IN_WIDTH-1:0] xu_reg [3];
    logic signed [IN_WIDTH-1:0] xv_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
            for (int i = 0; i < 3; i++)
            begin
                xu_reg[i] <= s_tdata[i*IN_WIDTH +: IN_WIDTH];
                xv_reg[i] <= s_tdata[(i+3)*IN_WIDTH +: IN_WIDTH];
            end
    end

    //------------------------------------------------------------------
    // S1: zero-length check and per-vector range reduction
    //------------------------------------------------------------------
    logic signed [XW-1:0] ue [3];
    logic signed [XW-1:0] ve [3];
    logic [SW-1:0]        su, sv;
    logic signed [RW-1:0] ur_reg [3];
    logic signed [RW-1:0] vr_reg [3];
    logic                 z1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ue[i] = XW'(xu_reg[i]);
            ve[i] = XW'(xv_reg[i]);
        end
        su = red_sh(ue[0], ue[1], ue[2]);
        sv = red_sh(ve[0], ve[1], ve[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ur_reg[i] <= RW'(ue[i] >>> su);
                vr_reg[i] <= RW'(ve[i] >>> sv);
            end
            z1_reg <= (xu_reg[0] == '0 && xu_reg[1] == '0 && xu_reg[2] == '0) ||
                      (xv_reg[0] == '0 && xv_reg[1] == '0 && xv_reg[2] == '0);
        end
    end

    //------------------------------------------------------------------
    // S2: dot product, cross product, squared norms
    //------------------------------------------------------------------
    logic signed [2*RW-1:0] pd [3];
    logic signed [2*RW-1:0] pc [6];
    logic signed [2*RW-1:0] pu [3];
    logic signed [2*RW-1:0] pv [3];
    logic signed [PW-1:0]   d2_reg;
    logic signed [PW-1:0]   c2_reg [3];
    logic [NW-1:0]          nu2_reg, nv2_reg;
    logic                   z2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pd[i] = ur_reg[i] * vr_reg[i];
            pu[i] = ur_reg[i] * ur_reg[i];
            pv[i] = vr_reg[i] * vr_reg[i];
        end
        pc[0] = ur_reg[1] * vr_reg[2];
        pc[1] = ur_reg[2] * vr_reg[1];
        pc[2] = ur_reg[2] * vr_reg[0];
        pc[3] = ur_reg[0] * vr_reg[2];
        pc[4] = ur_reg[0] * vr_reg[1];
        pc[5] = ur_reg[1] * vr_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg  <= PW'(pd[0]) + PW'(pd[1]) + PW'(pd[2]);
            for (int i = 0; i < 3; i++)
                c2_reg[i] <= PW'(pc[2*i]) - PW'(pc[2*i+1]);
            nu2_reg <= NW'(pu[0]) + NW'(pu[1]) + NW'(pu[2]);
            nv2_reg <= NW'(pv[0]) + NW'(pv[1]) + NW'(pv[2]);
            z2_reg  <= z1_reg;
        end
    end

    //------------------------------------------------------------------
    // S3: |c|^2 and |u|^2 |v|^2
    //------------------------------------------------------------------
    logic [NW-1:0]   cabs [3];
    logic [OP_W-1:0] csq  [3];
    side_t           side3_reg;
    logic [OP_W-1:0] nn3_reg, cc3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cabs[i] = c2_reg[i][PW-1] ? NW'(-c2_reg[i]) : NW'(c2_reg[i]);
            csq[i]  = cabs[i] * cabs[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg.d      <= d2_reg;
            for (int i = 0; i < 3; i++)
                side3_reg.c[i] <= c2_reg[i];
            side3_reg.tn     <= '0;
            side3_reg.tc     <= '0;
            side3_reg.status <= z2_reg ? ST_ZERO : ST_OK;
            nn3_reg          <= nu2_reg * nv2_reg;
            cc3_reg          <= csq[0] + csq[1] + csq[2];
        end
    end

    //------------------------------------------------------------------
    // S4: normalize counts, parallel check; S5: normalize shifts
    //------------------------------------------------------------------
    side_t           side4_next;
    side_t           side4_reg;
    logic [OP_W-1:0] nn4_reg, cc4_reg;

    always_comb
    begin
        side4_next    = side3_reg;
        side4_next.tn = lz_half(nn3_reg);
        side4_next.tc = lz_half(cc3_reg);
        if (side3_reg.status == ST_OK && cc3_reg == '0)
            side4_next.status = ST_PAR;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side4_reg    <= side4_next;
            nn4_reg      <= nn3_reg;
            cc4_reg      <= cc3_reg;
        end
    end

    sq_t   sq_reg [SQ_W+1][2];
    side_t ss_reg [SQ_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg[0]         <= side4_reg;
            sq_reg[0][0].rem  <= '0;
            sq_reg[0][0].root <= '0;
            sq_reg[0][0].op   <= nn4_reg << {side4_reg.tn, 1'b0};
            sq_reg[0][1].rem  <= '0;
            sq_reg[0][1].root <= '0;
            sq_reg[0][1].op   <= cc4_reg << {side4_reg.tc, 1'b0};
        end
    end

    //------------------------------------------------------------------
    // Square roots: one result bit per stage, norm and cross side by side
    //------------------------------------------------------------------
    for (genvar g = 0; g < SQ_W; g++)
    begin : g_sqrt
        logic [SQ_W+3:0] rs [2];
        logic [SQ_W+3:0] tr [2];
        sq_t             nx [2];

        always_comb
        begin
            for (int k = 0; k < 2; k++)
            begin
                rs[k]    = {sq_reg[g][k].rem, sq_reg[g][k].op[OP_W-1 -: 2]};
                tr[k]    = {2'b00, sq_reg[g][k].root, 2'b01};
                nx[k].op = sq_reg[g][k].op << 2;
                if (rs[k] >= tr[k])
                begin
                    nx[k].rem  = (SQ_W+2)'(rs[k] - tr[k]);
                    nx[k].root = {sq_reg[g][k].root[SQ_W-2:0], 1'b1};
                end
                else
                begin
                    nx[k].rem  = rs[k][SQ_W+1:0];
                    nx[k].root = {sq_reg[g][k].root[SQ_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[g+1] <= nx;
                ss_reg[g+1] <= ss_reg[g];
            end
        end
    end

    //------------------------------------------------------------------
    // D0: seven rounded numerators (cos, axis k, sin*k)
    //------------------------------------------------------------------
    logic signed [PW-1:0] a_sel [7];
    logic [TW-1:0]        t_sel [7];
    logic [SQ_W-1:0]      r_sel [7];
    logic [NW-1:0]        a_mag [7];
    dv_t                  dv_reg [QB+1][7];
    tag_t                 tg_reg [QB+1];

    always_comb
    begin
        a_sel[0] = ss_reg[SQ_W].d;
        t_sel[0] = ss_reg[SQ_W].tn;
        r_sel[0] = sq_reg[SQ_W][0].root;
        for (int i = 0; i < 3; i++)
        begin
            a_sel[1+i] = $signed(ss_reg[SQ_W].c[i]);
            t_sel[1+i] = ss_reg[SQ_W].tc;
            r_sel[1+i] = sq_reg[SQ_W][1].root;
            a_sel[4+i] = $signed(ss_reg[SQ_W].c[i]);
            t_sel[4+i] = ss_reg[SQ_W].tn;
            r_sel[4+i] = sq_reg[SQ_W][0].root;
        end
        for (int k = 0; k < 7; k++)
            a_mag[k] = a_sel[k][PW-1] ? NW'(-a_sel[k]) : NW'(a_sel[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 7; k++)
            begin
                dv_reg[0][k].rem <= ((OP_W'(a_mag[k]) << t_sel[k]) << QF) +
                                    OP_W'(r_sel[k] >> 1);
                dv_reg[0][k].den <= r_sel[k];
                dv_reg[0][k].q   <= '0;
                dv_reg[0][k].neg <= a_sel[k][PW-1];
            end
            tg_reg[0].status <= ss_reg[SQ_W].status;
            tg_reg[0].dpos   <= !ss_reg[SQ_W].d[PW-1] && ss_reg[SQ_W].d != '0;
        end
    end

    //------------------------------------------------------------------
    // Restoring division: one quotient bit per stage, msb first
    //------------------------------------------------------------------
    for (genvar g = 0; g < QB; g++)
    begin : g_div
        localparam int B = QB - 1 - g;
        logic [OP_W-1:0] dw [7];
        dv_t             nx [7];

        always_comb
        begin
            for (int k = 0; k < 7; k++)
            begin
                nx[k] = dv_reg[g][k];
                dw[k] = OP_W'(dv_reg[g][k].den);
                if ((dv_reg[g][k].rem >> B) >= dw[k])
                begin
                    nx[k].rem  = dv_reg[g][k].rem - (dw[k] << B);
                    nx[k].q[B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[g+1] <= nx;
                tg_reg[g+1] <= tg_reg[g];
            end
        end
    end

    //------------------------------------------------------------------
    // E1: signs back on, cos clamped to [-1, 1]
    //------------------------------------------------------------------
    logic signed [QB:0] qs [7];
    logic signed [QB:0] cq1_reg;
    logic signed [QB:0] k1_reg  [3];
    logic signed [QB:0] sk1_reg [3];
    tag_t               tg1_reg;

    always_comb
    begin
        for (int k = 0; k < 7; k++)
            qs[k] = dv_reg[QB][k].neg ? -$signed({1'b0, dv_reg[QB][k].q})
                                       :  $signed({1'b0, dv_reg[QB][k].q});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (qs[0] > ONE_Q)
                cq1_reg <= ONE_Q;
            else if (qs[0] < -ONE_Q)
                cq1_reg <= -ONE_Q;
            else
                cq1_reg <= qs[0];
            for (int i = 0; i < 3; i++)
            begin
                k1_reg[i]  <= qs[1+i];
                sk1_reg[i] <= qs[4+i];
            end
            tg1_reg <= tg_reg[QB];
        end
    end

    //------------------------------------------------------------------
    // E2: k k^T products; E3: round, 1 - cos; E4: times (1 - cos)
    //------------------------------------------------------------------
    logic signed [2*QB+1:0] kp2_reg [9];
    logic signed [QB:0]     cq2_reg, sk2_reg [3];
    tag_t                   tg2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    kp2_reg[i*3+j] <= k1_reg[i] * k1_reg[j];
            cq2_reg <= cq1_reg;
            sk2_reg <= sk1_reg;
            tg2_reg <= tg1_reg;
        end
    end

    logic signed [EW-1:0] kk3_reg [9];
    logic signed [EW-1:0] omc3_reg;
    logic signed [QB:0]   cq3_reg, sk3_reg [3];
    tag_t                 tg3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int n = 0; n < 9; n++)
                kk3_reg[n] <= rnd_q(MW'(kp2_reg[n]));
            omc3_reg <= ONE_M - EW'(cq2_reg);
            cq3_reg  <= cq2_reg;
            sk3_reg  <= sk2_reg;
            tg3_reg  <= tg2_reg;
        end
    end

    // 1 - cos is in [0, 2] and k_i k_j in [-1, 1]: both fit QB+1 bits
    logic signed [QB:0]     omc4;
    logic signed [QB:0]     kk4 [9];
    logic signed [2*QB+1:0] mp4 [9];
    logic signed [MW-1:0]   mp4_reg [9];
    logic signed [QB:0]     cq4_reg, sk4_reg [3];
    tag_t                   tg4_reg;

    always_comb
    begin
        omc4 = omc3_reg[QB:0];
        for (int n = 0; n < 9; n++)
        begin
            kk4[n] = kk3_reg[n][QB:0];
            mp4[n] = omc4 * kk4[n];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int n = 0; n < 9; n++)
                mp4_reg[n] <= MW'(mp4[n]);
            cq4_reg <= cq3_reg;
            sk4_reg <= sk3_reg;
            tg4_reg <= tg3_reg;
        end
    end

    //------------------------------------------------------------------
    // E5: assemble entries in Q30, special cases override
    //------------------------------------------------------------------
    logic signed [EW-1:0] m5 [9];
    logic signed [EW-1:0] m5_reg [9];
    logic [ST_W-1:0]      st5_reg;

    always_comb
    begin
        for (int n = 0; n < 9; n++)
            m5[n] = rnd_q(mp4_reg[n]);
        m5[0] = m5[0] + EW'(cq4_reg);
        m5[4] = m5[4] + EW'(cq4_reg);
        m5[8] = m5[8] + EW'(cq4_reg);
        // skew part sin*[k]x
        m5[1] = m5[1] - EW'(sk4_reg[2]);
        m5[2] = m5[2] + EW'(sk4_reg[1]);
        m5[3] = m5[3] + EW'(sk4_reg[2]);
        m5[5] = m5[5] - EW'(sk4_reg[0]);
        m5[6] = m5[6] - EW'(sk4_reg[1]);
        m5[7] = m5[7] + EW'(sk4_reg[0]);
        if (tg4_reg.status == ST_ZERO)
        begin
            for (int n = 0; n < 9; n++)
                m5[n] = (n % 4 == 0) ? ONE_M : '0;
        end
        else if (tg4_reg.status == ST_PAR)
        begin
            // +identity for same direction, -identity for opposite
            for (int n = 0; n < 9; n++)
                m5[n] = (n % 4 == 0) ? (tg4_reg.dpos ? ONE_M : -ONE_M) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m5_reg  <= m5;
            st5_reg <= tg4_reg.status;
        end
    end

    //------------------------------------------------------------------
    // E6: round to output fraction, clamp to +-1, output register
    //------------------------------------------------------------------
    logic [EW-1:0]    mg [9];
    logic [EW-1:0]    rr [9];
    logic [OUT_W-1:0] ro_reg [9];
    logic [ST_W-1:0]  st6_reg;

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            mg[n] = m5_reg[n][EW-1] ? EW'(-m5_reg[n]) : EW'(m5_reg[n]);
            rr[n] = (mg[n] + HALF) >> RSH;
            if (rr[n] > ONE_O)
                rr[n] = ONE_O;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int n = 0; n < 9; n++)
                ro_reg[n] <= m5_reg[n][EW-1] ? OUT_W'(-rr[n]) : OUT_W'(rr[n]);
            st6_reg <= st5_reg;
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int n = 0; n < 9; n++)
            m_tdata[n*OUT_W +: OUT_W] = ro_reg[n];
    end

    assign m_tuser = st6_reg;

endmodule

// ===== sv/vamr_checker.sv =====
// Port-level checks of the rotation matrix block, bound to the top level.
module vamr_checker #(
    parameter int OUT_FRAC_BITS = 14
) (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     s_tready,
    input logic                                     m_tvalid,
    input logic                                     m_tready,
    input logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    input logic [vamr_pkg::ST_W-1:0]                m_tuser
);
    import vamr_pkg::*;

    localparam int OUT_W = OUT_FRAC_BITS + 2;
    localparam logic [OUT_W-1:0] ONE_O = OUT_W'(64'd1 << OUT_FRAC_BITS);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a held result stalls the whole pipe
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_ZERO |->
            m_tdata[0 +: OUT_W] == ONE_O && m_tdata[4*OUT_W +: OUT_W] == ONE_O &&
            m_tdata[8*OUT_W +: OUT_W] == ONE_O && m_tdata[OUT_W +: OUT_W] == '0)
        else $error("zero-length input not identity");

    a_par: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_PAR |->
            m_tdata[0 +: OUT_W] == m_tdata[4*OUT_W +: OUT_W] &&
            m_tdata[4*OUT_W +: OUT_W] == m_tdata[8*OUT_W +: OUT_W] &&
            m_tdata[2*OUT_W +: OUT_W] == '0 && m_tdata[3*OUT_W +: OUT_W] == '0)
        else $error("parallel case not +-identity");

endmodule

bind vector_alignment_rotation_matrix vamr_checker #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_vamr_checker (.*);

// ===== verif/tb_vector_alignment_rotation_matrix.sv =====
// Testbench for the vector alignment rotation matrix block: stream stimulus and a result checker.
module tb_vector_alignment_rotation_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    import vamr_pkg::*;

    localparam int  OUT_W      = 16;     // Q1.14 entry width
    localparam int  FRAC       = 14;
    localparam int  CYCLE_CAP  = 600000; // far above the slowest correct run
    localparam int  PIPE_DRAIN = 120;

    typedef struct {
        logic [9*OUT_W-1:0] entries;  // r00 in the lowest bits
        logic [ST_W-1:0]    status;
    } rot_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // ux, uy, uz, vx, vy, vz
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;   // r00, r01, r02, r10, r11, r12, r20, r21, r22
    logic [ST_W-1:0] m_tuser; // status

    rot_result_t expected_mats[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          recv_holdoff = 0;

    vector_alignment_rotation_matrix dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Fixed point predictor
    // ---------------------------------------------------------------

    // floor integer square root, bit by bit
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // operand lifted by 4^t into [2^62, 2^64) before the root
    function automatic longint unsigned scaled_sqrt(longint unsigned p, output int t);
        t = 0;
        while ((p >> 62) == 0)
        begin
            p = p << 2;
            t++;
        end
        return int_sqrt(p);
    endfunction

    // a * 2^30 / (r / 2^t), rounded half away from zero
    function automatic longint q30_ratio(longint a, int t, longint unsigned r);
        longint unsigned mag;
        longint unsigned num;
        longint          q;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        num = (mag << t) << QF;
        q   = longint'((num + r / 2) / r);
        return (a < 0) ? -q : q;
    endfunction

    function automatic longint round_shift(longint v, int sh);
        longint unsigned mag;
        longint          q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q   = longint'((mag + (64'd1 << (sh - 1))) >> sh);
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic [OUT_W-1:0] to_q14(longint q30);
        longint v;
        v = round_shift(q30, QF - FRAC);
        if (v > (64'sd1 <<< FRAC))
            v = 64'sd1 <<< FRAC;
        if (v < -(64'sd1 <<< FRAC))
            v = -(64'sd1 <<< FRAC);
        return v[OUT_W-1:0];
    endfunction

    function automatic rot_result_t predict_rotation(logic [95:0] vec);
        longint          u[3];
        longint          v[3];
        longint          c[3];
        longint          k[3];
        longint          sk[3];
        longint          m[9];
        longint          dot;
        longint          cosq;
        longint          one;
        longint          t1;
        longint unsigned nu2;
        longint unsigned nv2;
        longint unsigned cc;
        longint unsigned rn;
        longint unsigned rc;
        longint unsigned mag;
        int              tn;
        int              tc;
        rot_result_t     res;
        one = 64'sd1 <<< QF;
        nu2 = 0;
        nv2 = 0;
        cc  = 0;
        res.status = ST_OK;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'($signed(vec[16*i +: 16]));
            v[i] = longint'($signed(vec[16*(i+3) +: 16]));
        end
        // 16-bit inputs already fit the reduced range: no pre-shift
        if ((u[0] == 0 && u[1] == 0 && u[2] == 0) || (v[0] == 0 && v[1] == 0 && v[2] == 0))
        begin
            res.status = ST_ZERO;
            for (int i = 0; i < 9; i++)
                m[i] = (i % 4 == 0) ? one : 0;
        end
        else
        begin
            dot  = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
            c[0] = u[1]*v[2] - u[2]*v[1];
            c[1] = u[2]*v[0] - u[0]*v[2];
            c[2] = u[0]*v[1] - u[1]*v[0];
            for (int i = 0; i < 3; i++)
            begin
                mag = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
                nu2 += longint'(u[i]*u[i]);
                nv2 += longint'(v[i]*v[i]);
                cc  += mag * mag;
            end
            if (cc == 0)
            begin
                // parallel or antiparallel: +-identity by sign of the dot product
                res.status = ST_PAR;
                for (int i = 0; i < 9; i++)
                    m[i] = (i % 4 == 0) ? ((dot > 0) ? one : -one) : 0;
            end
            else
            begin
                rn   = scaled_sqrt(nu2 * nv2, tn);
                rc   = scaled_sqrt(cc, tc);
                cosq = q30_ratio(dot, tn, rn);
                if (cosq > one)
                    cosq = one;
                if (cosq < -one)
                    cosq = -one;
                for (int i = 0; i < 3; i++)
                begin
                    k[i]  = q30_ratio(c[i], tc, rc);
                    sk[i] = q30_ratio(c[i], tn, rn);
                end
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                    begin
                        t1 = round_shift(k[i] * k[j], QF);
                        m[i*3+j] = round_shift((one - cosq) * t1, QF) + ((i == j) ? cosq : 0);
                    end
                m[1] -= sk[2];
                m[2] += sk[1];
                m[3] += sk[2];
                m[5] -= sk[0];
                m[6] -= sk[1];
                m[7] += sk[0];
            end
        end
        for (int i = 0; i < 9; i++)
            res.entries[OUT_W*i +: OUT_W] = to_q14(m[i]);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Monitors
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // expectations are queued on input acceptance; results checked in order
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_mats.size() == 0)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                rot_result_t want;
                want = expected_mats.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_tdata[OUT_W*i +: OUT_W] !== want.entries[OUT_W*i +: OUT_W])
                        report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                                        $signed(m_tdata[OUT_W*i +: OUT_W]),
                                        $signed(want.entries[OUT_W*i +: OUT_W]));
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
            end
        end
        if (rst_n && s_tvalid && s_tready)
            expected_mats.push_back(predict_rotation(s_tdata));
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or a counted long hold-off
    always @(negedge clk)
    begin
        if (recv_holdoff > 0)
        begin
            m_tready     <= 1'b0;
            recv_holdoff <= recv_holdoff - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // one vector pair; s_tvalid stays high into the next item unless idling
    task automatic send_pair(logic signed [15:0] ux, logic signed [15:0] uy,
                             logic signed [15:0] uz, logic signed [15:0] vx,
                             logic signed [15:0] vy, logic signed [15:0] vz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vz, vy, vx, uz, uy, ux};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_mats.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_comp(int mode);
        unique case (mode)
            0:       return 16'($urandom);
            1:       return $signed(16'($urandom_range(16))) - 16'sd8;
            default: return $signed(16'($urandom_range(512))) - 16'sd256;
        endcase
    endfunction

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pair(0, 0, 0, 1, 2, 3);                     // zero-length source
        send_pair(5, -7, 9, 0, 0, 0);                    // zero-length target
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(1, 2, 3, 2, 4, 6);                     // parallel
        send_pair(1, 2, 3, -3, -6, -9);                  // antiparallel
        send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
        send_pair(-32768, -32768, -32768, 32767, 32767, 32767);
        send_pair(32767, 32767, 32767, 32767, 32767, 32767);
        send_pair(-32768, 0, 0, 32767, 0, 0);
        send_pair(32767, 0, 0, 0, 32767, 0);             // orthogonal axes
        send_pair(0, 32767, 0, 0, 0, -32768);
        send_pair(0, 0, 1, 1, 0, 0);
        send_pair(-32768, 32767, -32768, 32767, -32768, 32767);
        send_pair(-32768, 32767, 0, 32767, -32768, 0);
        send_pair(32767, -32768, 1, -1, 32767, -32768);
        send_pair(1, 0, 0, 32767, 1, 0);                 // nearly parallel
        send_pair(1, 1, 0, -1, -1, 1);
        send_pair(-1, -1, -1, 1, 1, 1);
        send_pair(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC);
        wait_drained();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic signed [15:0] a[6];
        int                 kind;
        int                 mode;
        int                 scale;
        int                 zb;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            mode = $urandom_range(2);
            for (int i = 0; i < 6; i++)
                a[i] = rand_comp(mode);
            if (kind == 0)
            begin
                // scaled copy, sign may flip
                scale = $signed(32'($urandom_range(8))) - 4;
                a[0] = rand_comp(1);
                a[1] = rand_comp(1);
                a[2] = rand_comp(1);
                for (int i = 0; i < 3; i++)
                    a[i+3] = 16'(a[i] * scale);
            end
            else if (kind == 1)
            begin
                for (int i = 0; i < 3; i++)
                    a[i+3] = a[i] + 16'($signed(32'($urandom_range(2))) - 1);
            end
            else if (kind == 2)
            begin
                zb = $urandom_range(1) * 3;
                for (int i = 0; i < 3; i++)
                    a[zb+i] = 16'sd0;
            end
            send_pair(a[0], a[1], a[2], a[3], a[4], a[5]);
        end
        wait_drained();
    endtask

    // receiver holds off long enough to fill the pipe and stall the input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        recv_holdoff <= 300;
        for (int n = 0; n < 150; n++)
            send_pair(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(350, 0, 0);
        test_random(300, 68, 0);
        test_random(300, 0, 68);
        test_random(300, 6, 6);
        test_backpressure();

        wait_drained();
        repeat (PIPE_DRAIN) @(negedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
